@@ src/rc_pulse_capture_filter_assert.svh @@
// ---------------------------------------------------------------------------
// rc_pulse_capture_filter assertion macros
// Concurrent assertion wrappers shared by the capture filter RTL. They expect
// signals named clk and rst_n in the module that uses them.
// ---------------------------------------------------------------------------
`ifndef RC_PULSE_CAPTURE_FILTER_ASSERT_SVH
`define RC_PULSE_CAPTURE_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every edge once reset has been released.
`define RCPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RCPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RCPF_ASSERT(lbl, prop, msg)
`define RCPF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ src/rcpf_pkg.sv @@
// ---------------------------------------------------------------------------
// rcpf_pkg
// Types, constants and helpers shared by the RC pulse capture filter.
// ---------------------------------------------------------------------------
`default_nettype none

package rcpf_pkg;

  // Channel count and timestamp width of the capture logic.
  localparam int CHANNELS  = 4;
  localparam int TIME_BITS = 32;

  // Fixed widths of the ports.
  localparam int NUM_OUT   = 4;
  localparam int IN_TIME_W = 32;
  localparam int PIN_W     = 4;
  localparam int CFG_W     = 16;
  localparam int VAL_W     = 12;
  localparam int HIST_W    = 13;

  // Channels that can actually see edges and reach an output.
  localparam int ACT_CH = (CHANNELS < NUM_OUT) ? CHANNELS : NUM_OUT;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  // Reset values of the pulse window.
  localparam logic [CFG_W-1:0] MIN_PULSE_RST = 16'd800;
  localparam logic [CFG_W-1:0] MAX_PULSE_RST = 16'd2200;

  // Filter arithmetic: Q1.15 coefficients, accumulator sized for the worst case.
  localparam int ACC_W     = 30;
  localparam int FRAC_BITS = 15;
  localparam int COEF_B0   = 5666;
  localparam int COEF_B1   = 11331;
  localparam int COEF_B2   = 5666;
  localparam int COEF_A1   = 17370;
  localparam int COEF_A2   = 7265;

  typedef logic [TIME_BITS-1:0] tstamp_t;
  typedef logic [VAL_W-1:0]     val_t;
  typedef logic [HIST_W-1:0]    hist_t;

  typedef enum logic {
    CMD_EVENT = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_MIN_PULSE = 1'b0,
    REG_MAX_PULSE = 1'b1
  } reg_idx_t;

  // Per-channel control for one processed beat.
  typedef struct packed {
    logic evt;
    logic read;
    logic changed;
    logic level;
  } chan_ctl_t;

  // Brings the port timestamp to the internal width, truncating or zero-extending.
  function automatic tstamp_t to_tstamp(input logic [IN_TIME_W-1:0] t);
    tstamp_t r;
    r = '0;
    for (int i = 0; i < TIME_BITS && i < IN_TIME_W; i++) begin
      r[i] = t[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/rcpf_biquad.sv @@
// ---------------------------------------------------------------------------
// rcpf_biquad
// One pass of the second-order low-pass section with truncation and clamp.
// ---------------------------------------------------------------------------
`default_nettype none

module rcpf_biquad
  import rcpf_pkg::*;
(
  input  val_t  x0,
  input  val_t  x1,
  input  val_t  x2,
  input  hist_t y1,
  input  hist_t y2,
  output val_t  y
);

  logic [ACC_W-1:0]        p0, p1, p2, p3, p4;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-2-FRAC_BITS:0] quot;

  // All products are non-negative and the worst-case sum stays below 2^28.
  assign p0  = ACC_W'(x0) * ACC_W'(COEF_B0);
  assign p1  = ACC_W'(x1) * ACC_W'(COEF_B1);
  assign p2  = ACC_W'(x2) * ACC_W'(COEF_B2);
  assign p3  = ACC_W'(y1) * ACC_W'(COEF_A1);
  assign p4  = ACC_W'(y2) * ACC_W'(COEF_A2);
  assign acc = $signed(p0 + p1 + p2 + p3 - p4);

  // For a positive sum, the shift is the same as truncation toward zero.
  assign quot = acc[ACC_W-2:FRAC_BITS];

  always_comb begin
    if (acc[ACC_W-1] || (acc == '0)) begin
      y = '0;
    end else if (quot > $bits(quot)'(VAL_MAX)) begin
      y = VAL_MAX;
    end else begin
      y = quot[VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ src/rcpf_channel.sv @@
// ---------------------------------------------------------------------------
// rcpf_channel
// Capture state and filter history of one channel.
// ---------------------------------------------------------------------------
`default_nettype none

module rcpf_channel
  import rcpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  chan_ctl_t        ctl,
  input  tstamp_t          now,
  input  logic [CFG_W-1:0] min_pulse,
  input  logic [CFG_W-1:0] max_pulse,
  output val_t             read_val,
  output logic             pending
);

  `include "rc_pulse_capture_filter_assert.svh"

  tstamp_t rise_time_r, rise_time_nxt;
  val_t    raw_r, raw_nxt;
  logic    pending_r, pending_nxt;
  val_t    x1_r, x1_nxt, x2_r, x2_nxt;
  hist_t   y1_r, y1_nxt, y2_r, y2_nxt;

  tstamp_t width;
  logic    in_window;
  val_t    width_sat;
  val_t    filt;

  rcpf_biquad u_biquad (
    .x0 (raw_r),
    .x1 (x1_r),
    .x2 (x2_r),
    .y1 (y1_r),
    .y2 (y2_r),
    .y  (filt)
  );

  // The subtraction wraps at the timestamp width.
  assign width     = now - rise_time_r;
  assign in_window = (width > TIME_BITS'(min_pulse)) && (width < TIME_BITS'(max_pulse));
  assign width_sat = (width > TIME_BITS'(VAL_MAX)) ? VAL_MAX : width[VAL_W-1:0];

  always_comb begin
    rise_time_nxt = rise_time_r;
    raw_nxt       = raw_r;
    pending_nxt   = pending_r;
    x1_nxt        = x1_r;
    x2_nxt        = x2_r;
    y1_nxt        = y1_r;
    y2_nxt        = y2_r;
    if (ctl.evt && ctl.changed) begin
      if (ctl.level) begin
        rise_time_nxt = now;
      end else if (in_window) begin
        raw_nxt     = width_sat;
        pending_nxt = 1'b1;
      end
    end
    if (ctl.read && pending_r) begin
      pending_nxt = 1'b0;
      raw_nxt     = filt;
      x1_nxt      = raw_r;
      x2_nxt      = x1_r;
      y1_nxt      = HIST_W'(filt);
      y2_nxt      = y1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_time_r <= '0;
      raw_r       <= '0;
      pending_r   <= 1'b0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
    end else begin
      rise_time_r <= rise_time_nxt;
      raw_r       <= raw_nxt;
      pending_r   <= pending_nxt;
      x1_r        <= x1_nxt;
      x2_r        <= x2_nxt;
      y1_r        <= y1_nxt;
      y2_r        <= y2_nxt;
    end
  end

  assign read_val = pending_r ? filt : raw_r;
  assign pending  = pending_r;

  `RCPF_ASSERT(a_read_clears_pending, ctl.read |=> !pending_r, "read left channel pending")
  `RCPF_ASSERT(a_pending_held, (pending_r && !ctl.read) |=> pending_r, "pending lost without read")
  `RCPF_ASSERT(a_rise_only_on_edge, !(ctl.evt && ctl.changed) |=> $stable(rise_time_r),
               "rise time moved without an edge")

endmodule

`default_nettype wire

@@ src/rc_pulse_capture_filter.sv @@
// ---------------------------------------------------------------------------
// rc_pulse_capture_filter
// Four-channel RC pulse-width capture with a per-channel low-pass filter.
// ---------------------------------------------------------------------------
// Input beats carry a command. A pin event gives a microsecond timestamp, a
// mask of channels with an edge and their levels; rising edges record the
// time and falling edges that close a pulse strictly inside the window set by
// cfg registers 0 (minimum) and 1 (maximum) latch a new raw width. Pin events
// produce no result beat. A read beat filters every channel that has a new
// width and returns one result beat with all four values and a flag.
// A taken beat sits in the input register and is processed from there; a read
// result goes to the result register and stays on the out_ ports until taken.
// Throughput is one beat per cycle unless a read waits on out_stall, set by
// the single input register and the single result register.
// When out_stall holds a result, a following pin event still proceeds; a
// following read waits in the input register and in_stall rises. Reset clears
// all capture and filter state and restores the window to 800..2200 us. The
// user must write configuration only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

module rc_pulse_capture_filter
  import rcpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [IN_TIME_W-1:0] in_time_us,
  input  logic [PIN_W-1:0]     in_changed_pins,
  input  logic [PIN_W-1:0]     in_pin_levels,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VAL_W-1:0]     out_channel_0,
  output logic [VAL_W-1:0]     out_channel_1,
  output logic [VAL_W-1:0]     out_channel_2,
  output logic [VAL_W-1:0]     out_channel_3,
  output logic                 out_any_updated,
  input  logic                 cfg_wr_en,
  input  logic [0:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  `include "rc_pulse_capture_filter_assert.svh"

  logic [CFG_W-1:0] min_pulse_r, min_pulse_nxt;
  logic [CFG_W-1:0] max_pulse_r, max_pulse_nxt;

  logic                 s1_valid_r, s1_valid_nxt;
  cmd_t                 s1_cmd_r;
  logic [IN_TIME_W-1:0] s1_time_r;
  logic [PIN_W-1:0]     s1_changed_r;
  logic [PIN_W-1:0]     s1_levels_r;

  logic       out_valid_r, out_valid_nxt;
  val_t       out_val_r [NUM_OUT];
  logic       out_any_r;

  logic       in_accept;
  logic       out_free;
  logic       s1_fire;
  logic       read_fire;
  tstamp_t    now;
  val_t       chan_val [NUM_OUT];
  logic [NUM_OUT-1:0] chan_pend;

  // Configuration writes.
  always_comb begin
    min_pulse_nxt = min_pulse_r;
    max_pulse_nxt = max_pulse_r;
    if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_MIN_PULSE: min_pulse_nxt = cfg_wdata;
        REG_MAX_PULSE: max_pulse_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r <= MIN_PULSE_RST;
      max_pulse_r <= MAX_PULSE_RST;
    end else begin
      min_pulse_r <= min_pulse_nxt;
      max_pulse_r <= max_pulse_nxt;
    end
  end

  // Handshake. A pin event never waits; a read waits only for a free result slot.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && ((s1_cmd_r == CMD_EVENT) || out_free);
  assign read_fire = s1_fire && (s1_cmd_r == CMD_READ);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = read_fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r     <= cmd_t'(in_command);
      s1_time_r    <= in_time_us;
      s1_changed_r <= in_changed_pins;
      s1_levels_r  <= in_pin_levels;
    end
  end

  assign now = to_tstamp(s1_time_r);

  for (genvar i = 0; i < NUM_OUT; i++) begin : g_chan
    if (i < ACT_CH) begin : g_live
      chan_ctl_t ctl;

      assign ctl.evt     = s1_fire && (s1_cmd_r == CMD_EVENT);
      assign ctl.read    = read_fire;
      assign ctl.changed = s1_changed_r[i];
      assign ctl.level   = s1_levels_r[i];

      rcpf_channel u_chan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .now       (now),
        .min_pulse (min_pulse_r),
        .max_pulse (max_pulse_r),
        .read_val  (chan_val[i]),
        .pending   (chan_pend[i])
      );
    end else begin : g_absent
      assign chan_val[i]  = '0;
      assign chan_pend[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_fire) begin
      for (int i = 0; i < NUM_OUT; i++) begin
        out_val_r[i] <= chan_val[i];
      end
      out_any_r <= |chan_pend;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_0   = out_val_r[0];
  assign out_channel_1   = out_val_r[1];
  assign out_channel_2   = out_val_r[2];
  assign out_channel_3   = out_val_r[3];
  assign out_any_updated = out_any_r;

  `RCPF_ASSERT(a_read_loads_result, read_fire |=> out_valid_r, "read produced no result")
  `RCPF_ASSERT(a_stall_only_for_read, in_stall |-> (s1_valid_r && s1_cmd_r == CMD_READ),
               "input stalled without a waiting read")
  `RCPF_ASSERT(a_no_result_without_read, (!out_valid_r && !read_fire) |=> !out_valid_r,
               "result appeared without a read")

endmodule

`default_nettype wire

@@ tb/rc_pulse_capture_filter_test.sv @@
// ---------------------------------------------------------------------------
// rc_pulse_capture_filter_test
// Self-checking bench for the four-channel pulse capture and low-pass filter.
// Pin events and reads are driven on the input channel while a local copy of
// the capture and filter state predicts every read result. Directed checks of
// the window edges, wrap-around, long pulses and empty windows come first,
// then random pulse traffic under several window settings and stall patterns.
// ---------------------------------------------------------------------------
module rc_pulse_capture_filter_test;
  import rcpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF       = 4;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT   = 10;

  // Smoothing coefficients, Q1.15.
  localparam longint K_B0 = 5666;
  localparam longint K_B1 = 11331;
  localparam longint K_B2 = 5666;
  localparam longint K_A1 = 17370;
  localparam longint K_A2 = 7265;

  typedef struct packed {
    logic                   any;
    val_t [NUM_OUT-1:0]     chan;
  } reading_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_command;
  logic [IN_TIME_W-1:0] in_time_us;
  logic [PIN_W-1:0]     in_changed_pins;
  logic [PIN_W-1:0]     in_pin_levels;
  logic                 out_valid;
  logic                 out_stall;
  logic [VAL_W-1:0]     out_channel_0;
  logic [VAL_W-1:0]     out_channel_1;
  logic [VAL_W-1:0]     out_channel_2;
  logic [VAL_W-1:0]     out_channel_3;
  logic                 out_any_updated;
  logic                 cfg_wr_en;
  logic [0:0]           cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Local copy of the capture and filter state.
  logic [CFG_W-1:0] win_min;
  logic [CFG_W-1:0] win_max;
  tstamp_t          pulse_rise [ACT_CH];
  val_t             pulse_width [ACT_CH];
  logic             pulse_new [ACT_CH];
  val_t             x_hist [ACT_CH][2];
  hist_t            y_hist [ACT_CH][2];

  reading_t expected_readings [$];
  int       fail_count;
  int       sender_idle_pct;
  int       receiver_stall_pct;
  int       quiet_cycles;

  rc_pulse_capture_filter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_time_us      (in_time_us),
    .in_changed_pins (in_changed_pins),
    .in_pin_levels   (in_pin_levels),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_channel_0   (out_channel_0),
    .out_channel_1   (out_channel_1),
    .out_channel_2   (out_channel_2),
    .out_channel_3   (out_channel_3),
    .out_any_updated (out_any_updated),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---- prediction -------------------------------------------------------

  function automatic void clear_capture_state();
    win_min = MIN_PULSE_RST;
    win_max = MAX_PULSE_RST;
    for (int i = 0; i < ACT_CH; i++) begin
      pulse_rise[i]  = '0;
      pulse_width[i] = '0;
      pulse_new[i]   = 1'b0;
      x_hist[i][0]   = '0;
      x_hist[i][1]   = '0;
      y_hist[i][0]   = '0;
      y_hist[i][1]   = '0;
    end
  endfunction

  function automatic void capture_pin_event(tstamp_t now, logic [PIN_W-1:0] changed,
                                            logic [PIN_W-1:0] levels);
    tstamp_t width;
    for (int i = 0; i < ACT_CH; i++) begin
      if (changed[i]) begin
        if (levels[i]) begin
          pulse_rise[i] = now;
        end else begin
          width = now - pulse_rise[i];
          if (width > tstamp_t'(win_min) && width < tstamp_t'(win_max)) begin
            pulse_width[i] = (width > tstamp_t'(VAL_MAX)) ? VAL_MAX : val_t'(width);
            pulse_new[i]   = 1'b1;
          end
        end
      end
    end
  endfunction

  // One pass of the second-order low-pass on a channel with a fresh width.
  function automatic void smooth_channel(int i);
    longint acc;
    longint q;
    val_t   y;
    acc = K_B0 * longint'(pulse_width[i]) + K_B1 * longint'(x_hist[i][0])
        + K_B2 * longint'(x_hist[i][1]) + K_A1 * longint'(y_hist[i][0])
        - K_A2 * longint'(y_hist[i][1]);
    if (acc <= 0) begin
      y = '0;
    end else begin
      q = acc / 32768;
      y = (q > longint'(VAL_MAX)) ? VAL_MAX : val_t'(q);
    end
    x_hist[i][1]   = x_hist[i][0];
    x_hist[i][0]   = pulse_width[i];
    y_hist[i][1]   = y_hist[i][0];
    y_hist[i][0]   = hist_t'(y);
    pulse_width[i] = y;
  endfunction

  function automatic reading_t read_channels();
    reading_t r;
    r = '0;
    for (int i = 0; i < ACT_CH; i++) begin
      if (pulse_new[i]) begin
        pulse_new[i] = 1'b0;
        smooth_channel(i);
        r.any = 1'b1;
      end
      r.chan[i] = pulse_width[i];
    end
    return r;
  endfunction

  // ---- driving ----------------------------------------------------------

  // Entered and left just after a falling edge.
  task automatic send_beat(cmd_t cmd, tstamp_t t, logic [PIN_W-1:0] changed,
                           logic [PIN_W-1:0] levels);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_time_us      <= t;
    in_changed_pins <= changed;
    in_pin_levels   <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_READ) begin
      expected_readings.push_back(read_channels());
    end else begin
      capture_pin_event(t, changed, levels);
    end
    @(negedge clk);
  endtask

  task automatic send_read();
    send_beat(CMD_READ, $urandom, 4'($urandom), 4'($urandom));
  endtask

  // Waits for every outstanding reading, then lets any pin event in flight land.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MIN_PULSE;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MAX_PULSE;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    win_min = lo;
    win_max = hi;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // ---- checking ---------------------------------------------------------

  always @(posedge clk) begin : check_results
    reading_t got;
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.any     = out_any_updated;
      got.chan[0] = out_channel_0;
      got.chan[1] = out_channel_1;
      got.chan[2] = out_channel_2;
      got.chan[3] = out_channel_3;
      if (expected_readings.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result beat: ch %0d %0d %0d %0d any %0b",
                   got.chan[0], got.chan[1], got.chan[2], got.chan[3], got.any);
      end else begin
        want = expected_readings.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display({"mismatch: expected ch %0d %0d %0d %0d any %0b, ",
                      "got ch %0d %0d %0d %0d any %0b"},
                     want.chan[0], want.chan[1], want.chan[2], want.chan[3], want.any,
                     got.chan[0], got.chan[1], got.chan[2], got.chan[3], got.any);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---- tests ------------------------------------------------------------

  // A read straight after reset, then a falling edge with no rise seen yet.
  task automatic test_reset_state();
    send_beat(CMD_READ, 32'hFFFF_FFFF, 4'hF, 4'hF);
    send_beat(CMD_EVENT, 32'd1000, 4'b0001, 4'b0000);
    send_read();
  endtask

  // Widths on and just inside both window limits, with the timestamp wrapping.
  task automatic test_window_edges();
    tstamp_t t0;
    t0 = 32'hFFFF_FF00;
    send_beat(CMD_EVENT, t0, 4'hF, 4'hF);
    send_beat(CMD_EVENT, t0 + 800, 4'b0001, 4'b1110);
    send_beat(CMD_EVENT, t0 + 801, 4'b0010, 4'b1101);
    send_beat(CMD_EVENT, t0 + 2199, 4'b0100, 4'b1011);
    send_beat(CMD_EVENT, t0 + 2200, 4'b1000, 4'b0111);
    send_read();
    send_beat(CMD_EVENT, 32'd0, 4'b0000, 4'b0000);
    send_read();
  endtask

  // Widest window: pulses longer than the output range saturate, a width of
  // one is taken and a width of zero is not.
  task automatic test_long_pulse();
    write_window(16'd0, 16'hFFFF);
    send_beat(CMD_EVENT, 32'd0, 4'hF, 4'hF);
    send_beat(CMD_EVENT, 32'd5000, 4'hF, 4'h0);
    send_read();
    send_read();
    send_beat(CMD_EVENT, 32'd10, 4'b0011, 4'b0011);
    send_beat(CMD_EVENT, 32'd11, 4'b0001, 4'b0000);
    send_beat(CMD_EVENT, 32'd10, 4'b0010, 4'b0000);
    send_read();
  endtask

  // Windows that can hold no width at all.
  task automatic test_empty_window();
    write_window(16'd1000, 16'd1001);
    send_beat(CMD_EVENT, 32'd100, 4'hF, 4'hF);
    send_beat(CMD_EVENT, 32'd1100, 4'b0101, 4'b0000);
    send_beat(CMD_EVENT, 32'd1101, 4'b1010, 4'b0000);
    send_read();
    write_window(16'hFFFF, 16'd0);
    send_beat(CMD_EVENT, 32'd0, 4'hF, 4'hF);
    send_beat(CMD_EVENT, 32'd30000, 4'hF, 4'h0);
    send_read();
  endtask

  // Mostly well-formed pulses around the window edges, with reads and noise.
  task automatic test_random_traffic(int items, int idle_pct, int stall_pct,
                                     logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    int               pick;
    int               ch;
    int               w_lo;
    int               w_hi;
    logic [PIN_W-1:0] mask;
    write_window(lo, hi);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    w_lo = (int'(lo) > 3) ? int'(lo) - 3 : 0;
    w_hi = int'(hi) + 3;
    if (w_hi < w_lo) w_hi = w_lo + 8;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 33) begin
        mask = 4'($urandom_range(15, 1));
        send_beat(CMD_EVENT, $urandom, mask, mask | (4'($urandom) & ~mask));
      end else if (pick < 70) begin
        ch   = $urandom_range(ACT_CH - 1);
        mask = 4'(1 << ch);
        if ($urandom_range(3) == 0) mask = mask | 4'($urandom);
        send_beat(CMD_EVENT, pulse_rise[ch] + tstamp_t'($urandom_range(w_hi, w_lo)),
                  mask, 4'($urandom) & ~4'(1 << ch));
      end else if (pick < 88) begin
        send_read();
      end else begin
        send_beat(CMD_EVENT, $urandom, 4'($urandom), 4'($urandom));
      end
      // One pause in each phase lets every outstanding reading come back.
      if (n == items / 2) drain();
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_command         = CMD_EVENT;
    in_time_us         = '0;
    in_changed_pins    = '0;
    in_pin_levels      = '0;
    out_stall          = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_index          = REG_MIN_PULSE;
    cfg_wdata          = '0;
    fail_count         = 0;
    quiet_cycles       = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    clear_capture_state();
    // Counting rising edges keeps the reset length independent of start-up order.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_window_edges();
    test_long_pulse();
    test_empty_window();
    test_random_traffic(95, 0, 0, MIN_PULSE_RST, MAX_PULSE_RST);
    test_random_traffic(95, 76, 0, 16'd0, 16'hFFFF);
    test_random_traffic(95, 0, 76, 16'd1500, 16'd1600);
    test_random_traffic(95, 24, 24, 16'd3000, 16'd6000);

    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ rc_pulse_capture_filter.f @@
+incdir+src
src/rcpf_pkg.sv
src/rcpf_biquad.sv
src/rcpf_channel.sv
src/rc_pulse_capture_filter.sv
tb/rc_pulse_capture_filter_test.sv
